// File: src/waypoint_trajectory_interpolator_top_assert.svh
// Assertion macros used by the interpolator engine RTL.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef WAYPOINT_TRAJECTORY_INTERPOLATOR_TOP_ASSERT_SVH
`define WAYPOINT_TRAJECTORY_INTERPOLATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define WTI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define WTI_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WTI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define WTI_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// File: src/wtint_pkg.sv
// Shared types, constants and the arctangent table of the interpolator.
// No dependencies.
package wtint_pkg;

    localparam int DEF_POINTS_PER_SEGMENT = 5;
    localparam int DEF_CORDIC_ITERATIONS  = 16;
    localparam int CORDIC_MAX_ITERATIONS  = 24;
    localparam int QUEUE_DEPTH            = 2;

    localparam logic signed [20:0] PI_Q16   = 21'sd205887;
    localparam logic signed [20:0] HEAD_LIM = 21'sd205888;

    localparam logic [30:0] RST_MAX_SPEED      = 31'd163840;
    localparam logic [30:0] RST_INTERVAL_RECIP = 31'd655360;
    localparam logic [30:0] RST_PT_PERIOD      = 31'd1311;
    localparam logic [6:0]  RST_TRACKED        = 7'd5;
    localparam logic [30:0] TIME_MAX           = 31'h7FFF_FFFF;

    // configuration register indexes
    localparam logic [1:0] REG_MAX_SPEED      = 2'd0;
    localparam logic [1:0] REG_INTERVAL_RECIP = 2'd1;
    localparam logic [1:0] REG_PT_PERIOD      = 2'd2;
    localparam logic [1:0] REG_TRACKED        = 2'd3;

    typedef struct packed {
        logic [30:0] max_speed;
        logic [30:0] interval_recip;
        logic [30:0] pt_period;
        logic [6:0]  tracked_segments;
    } cfg_t;

    // one accepted segment, classified by the front end
    typedef struct packed {
        logic signed [31:0] x0;
        logic signed [31:0] y0;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic [6:0]         seg;
        logic               new_path;
    } seg_item_t;

    typedef struct packed {
        logic               last;
        logic signed [31:0] vel_yaw;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_x;
        logic signed [18:0] heading;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
        logic [30:0]        time_from_start;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_UNIT, S_VX, S_VY, S_ANGLE, S_VH,
        S_STEP, S_PX, S_PY, S_PH, S_EMIT, S_FINISH
    } eng_state_t;

    typedef enum logic [1:0] {
        C_IDLE, C_NORM, C_ITER, C_DONE
    } cordic_phase_t;

    function automatic logic [15:0] atan_entry(input logic [4:0] i);
        logic [15:0] v;
        case (i)
            5'd0:  v = 16'd51472;
            5'd1:  v = 16'd30386;
            5'd2:  v = 16'd16055;
            5'd3:  v = 16'd8150;
            5'd4:  v = 16'd4091;
            5'd5:  v = 16'd2047;
            5'd6:  v = 16'd1024;
            5'd7:  v = 16'd512;
            5'd8:  v = 16'd256;
            5'd9:  v = 16'd128;
            5'd10: v = 16'd64;
            5'd11: v = 16'd32;
            5'd12: v = 16'd16;
            5'd13: v = 16'd8;
            5'd14: v = 16'd4;
            5'd15: v = 16'd2;
            5'd16: v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

// File: src/wtint_queue.sv
// Short FIFO of classified segments between front end and engine.
// Depends on wtint_pkg.
module wtint_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  wtint_pkg::seg_item_t  push_item,
    output logic                  full,
    input  logic                  pop,
    output logic                  avail,
    output wtint_pkg::seg_item_t  head
);
    localparam int AW = (wtint_pkg::QUEUE_DEPTH > 1) ? $clog2(wtint_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(wtint_pkg::QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(wtint_pkg::QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_C  = AW'(wtint_pkg::QUEUE_DEPTH - 1);

    wtint_pkg::seg_item_t mem_reg [wtint_pkg::QUEUE_DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] cnt_reg;

    assign full  = (cnt_reg == DEPTH_C);
    assign avail = (cnt_reg != '0);
    assign head  = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == LAST_C) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == LAST_C) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end
endmodule

// File: src/wtint_front.sv
// Front end: accepts waypoints, tracks the previous point and segment count,
// drops waypoints past the tracked segments. Depends on wtint_pkg.
module wtint_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic signed [31:0]    way_x,
    input  logic signed [31:0]    way_y,
    input  logic                  path_start,
    input  logic [6:0]            tracked_segments,
    input  logic                  q_full,
    output logic                  q_push,
    output wtint_pkg::seg_item_t  q_item
);
    logic signed [31:0] prev_x_reg, prev_y_reg;
    logic [6:0]         seg_reg;
    logic               accept;
    logic [6:0]         seg_eff;
    logic signed [31:0] x0, y0;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign seg_eff  = path_start ? 7'd0 : seg_reg;
    assign x0       = path_start ? 32'sd0 : prev_x_reg;
    assign y0       = path_start ? 32'sd0 : prev_y_reg;
    assign q_push   = accept && (seg_eff < tracked_segments);

    always_comb begin
        q_item.x0       = x0;
        q_item.y0       = y0;
        q_item.dx       = $signed({way_x[31], way_x}) - $signed({x0[31], x0});
        q_item.dy       = $signed({way_y[31], way_y}) - $signed({y0[31], y0});
        q_item.seg      = seg_eff;
        // first segment since reset or a path start: heading restarts from zero
        q_item.new_path = (seg_eff == 7'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            seg_reg    <= '0;
        end else if (q_push) begin
            prev_x_reg <= way_x;
            prev_y_reg <= way_y;
            seg_reg    <= seg_eff + 7'd1;
        end else if (accept && path_start) begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            seg_reg    <= '0;
        end
    end
endmodule

// File: src/wtint_mulq.sv
// Sequential signed-by-unsigned Q16.16 multiply, (d*f)>>16 toward zero,
// built from two 17x31 partial products. Depends on nothing.
module wtint_mulq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic signed [33:0]  d,
    input  logic [30:0]         f,
    output logic                done,
    output logic signed [50:0]  prod
);
    logic [33:0] mag_reg;
    logic        neg_reg;
    logic [30:0] f_reg;
    logic [1:0]  step_reg;
    logic [47:0] pp_reg, acc_reg;
    logic [16:0] op;
    logic [64:0] sum;
    logic [48:0] shifted;

    assign op      = (step_reg == 2'd1) ? mag_reg[16:0] : mag_reg[33:17];
    assign sum     = {17'd0, acc_reg} + {pp_reg, 17'd0};
    assign shifted = sum[64:16];

    always_ff @(posedge aclk) begin
        if (start) begin
            mag_reg <= d[33] ? 34'(-d) : 34'(d);
            neg_reg <= d[33];
            f_reg   <= f;
        end
        if (step_reg == 2'd1 || step_reg == 2'd2) begin
            pp_reg <= 48'(op) * 48'(f_reg);
        end
        if (step_reg == 2'd2) begin
            acc_reg <= pp_reg;
        end
        if (step_reg == 2'd3) begin
            prod <= neg_reg ? -$signed({2'b0, shifted}) : $signed({2'b0, shifted});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            done     <= 1'b0;
        end else begin
            done <= (step_reg == 2'd3);
            if (start) begin
                step_reg <= 2'd1;
            end else if (step_reg != 2'd0) begin
                step_reg <= step_reg + 2'd1;
            end
        end
    end
endmodule

// File: src/wtint_cordic.sv
// Vectoring CORDIC atan2 of a segment delta, one rotation per cycle after a
// normalising pre-shift. Depends on wtint_pkg.
module wtint_cordic #(
    parameter int CORDIC_ITERATIONS = wtint_pkg::DEF_CORDIC_ITERATIONS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic signed [32:0]  dx,
    input  logic signed [32:0]  dy,
    output logic                done,
    output logic signed [18:0]  angle
);
    localparam int XW = 46;
    localparam int NIT = (CORDIC_ITERATIONS > wtint_pkg::CORDIC_MAX_ITERATIONS)
                         ? wtint_pkg::CORDIC_MAX_ITERATIONS : CORDIC_ITERATIONS;
    localparam logic [4:0] LAST_IT = 5'(NIT - 1);

    wtint_pkg::cordic_phase_t phase_reg, phase_next;
    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [20:0]   z_reg;
    logic [4:0]           it_reg;
    logic [XW-1:0]        ax, ay, axs, ays;
    logic signed [XW-1:0] xs, ys;
    logic                 big, tiny;
    logic signed [20:0]   at;

    assign ax   = x_reg[XW-1] ? XW'(-x_reg) : XW'(x_reg);
    assign ay   = y_reg[XW-1] ? XW'(-y_reg) : XW'(y_reg);
    assign axs  = ax >> it_reg;
    assign ays  = ay >> it_reg;
    assign xs   = x_reg[XW-1] ? -$signed(axs) : $signed(axs);
    assign ys   = y_reg[XW-1] ? -$signed(ays) : $signed(ays);
    assign big  = (ax[XW-1:40] != '0) || (ay[XW-1:40] != '0);
    assign tiny = (ax[XW-1:32] == '0) && (ay[XW-1:32] == '0);
    assign at   = $signed({5'd0, wtint_pkg::atan_entry(it_reg)});

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            wtint_pkg::C_IDLE: begin
                if (start) begin
                    phase_next = (dy == '0) ? wtint_pkg::C_DONE : wtint_pkg::C_NORM;
                end
            end
            wtint_pkg::C_NORM: if (big) phase_next = wtint_pkg::C_ITER;
            wtint_pkg::C_ITER: if (it_reg == LAST_IT) phase_next = wtint_pkg::C_DONE;
            wtint_pkg::C_DONE: phase_next = wtint_pkg::C_IDLE;
            default:           phase_next = wtint_pkg::C_IDLE;
        endcase
    end

    always_comb begin
        done = (phase_reg == wtint_pkg::C_DONE);
        if (z_reg > wtint_pkg::HEAD_LIM) begin
            angle = 19'(wtint_pkg::HEAD_LIM);
        end else if (z_reg < -wtint_pkg::HEAD_LIM) begin
            angle = 19'(-wtint_pkg::HEAD_LIM);
        end else begin
            angle = 19'(z_reg);
        end
    end

    always_ff @(posedge aclk) begin
        case (phase_reg)
            wtint_pkg::C_IDLE: begin
                it_reg <= '0;
                if (start) begin
                    if (dy == '0) begin
                        z_reg <= dx[32] ? wtint_pkg::PI_Q16 : 21'sd0;
                    end else if (dx[32]) begin
                        z_reg <= dy[32] ? -wtint_pkg::PI_Q16 : wtint_pkg::PI_Q16;
                        x_reg <= -XW'(dx);
                        y_reg <= -XW'(dy);
                    end else begin
                        z_reg <= 21'sd0;
                        x_reg <= XW'(dx);
                        y_reg <= XW'(dy);
                    end
                end
            end
            wtint_pkg::C_NORM: begin
                if (!big) begin
                    x_reg <= tiny ? x_reg <<< 8 : x_reg <<< 1;
                    y_reg <= tiny ? y_reg <<< 8 : y_reg <<< 1;
                end
            end
            wtint_pkg::C_ITER: begin
                it_reg <= it_reg + 5'd1;
                if (y_reg > 0) begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + at;
                end else begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - at;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= wtint_pkg::C_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end
endmodule

// File: src/wtint_engine.sv
// Back end: reciprocal divide, velocities, heading, point interpolation and
// the output register. Depends on wtint_pkg, wtint_mulq, wtint_cordic.
`include "waypoint_trajectory_interpolator_top_assert.svh"
module wtint_engine #(
    parameter int POINTS_PER_SEGMENT = wtint_pkg::DEF_POINTS_PER_SEGMENT,
    parameter int CORDIC_ITERATIONS  = wtint_pkg::DEF_CORDIC_ITERATIONS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  wtint_pkg::cfg_t       cfg,
    input  logic                  q_avail,
    input  wtint_pkg::seg_item_t  q_head,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output wtint_pkg::out_item_t  m_item
);
    localparam int KW = $clog2(POINTS_PER_SEGMENT + 1);
    localparam logic [KW-1:0] K_LAST = KW'(POINTS_PER_SEGMENT);

    wtint_pkg::eng_state_t state_reg, state_next;
    wtint_pkg::seg_item_t  item_reg;
    wtint_pkg::out_item_t  out_reg;
    logic               out_valid_reg;
    logic signed [18:0] h0_reg, h1_reg, ph_reg;
    logic               h1_ok_reg;
    logic signed [19:0] dh_reg;
    logic signed [31:0] vx_reg, vy_reg, vh_reg, px_reg, py_reg;
    logic [30:0]        interval_reg, rem_reg, frac_reg;
    logic [32:0]        quot_reg;
    logic [5:0]         dcnt_reg;
    logic [46:0]        unit_reg;
    logic [38:0]        t_reg;
    logic [KW-1:0]      k_reg;
    logic               mul_go_reg;

    logic               mul_start, mul_done, is_mul, out_free, emit;
    logic signed [33:0] mul_d;
    logic [30:0]        mul_f;
    logic signed [50:0] prod;
    logic               cordic_done;
    logic signed [18:0] cordic_angle;
    logic [32:0]        num;
    logic [31:0]        rem_sh;
    logic               rem_ge;
    logic [32:0]        quot_next;
    logic [47:0]        frac_sum;

    function automatic logic signed [31:0] vclamp(input logic signed [50:0] p,
                                                  input logic [30:0] lim);
        logic signed [50:0] l;
        l = $signed({20'd0, lim});
        if (p > l) return $signed({1'b0, lim});
        if (p < -l) return -$signed({1'b0, lim});
        return 32'(p);
    endfunction

    function automatic logic signed [31:0] pclamp(input logic signed [31:0] b,
                                                  input logic signed [50:0] p);
        logic signed [51:0] s;
        s = 52'(b) + 52'(p);
        if (s > 52'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (s < -52'sh8000_0000) return 32'sh8000_0000;
        return 32'(s);
    endfunction

    function automatic logic signed [18:0] hclamp(input logic signed [18:0] b,
                                                  input logic signed [50:0] p);
        logic signed [51:0] s;
        s = 52'(b) + 52'(p);
        if (s > 52'(wtint_pkg::HEAD_LIM)) return 19'(wtint_pkg::HEAD_LIM);
        if (s < 52'(-wtint_pkg::HEAD_LIM)) return 19'(-wtint_pkg::HEAD_LIM);
        return 19'(s);
    endfunction

    wtint_mulq u_mulq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .d       (mul_d),
        .f       (mul_f),
        .done    (mul_done),
        .prod    (prod)
    );

    wtint_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (q_pop),
        .dx      (q_head.dx),
        .dy      (q_head.dy),
        .done    (cordic_done),
        .angle   (cordic_angle)
    );

    // rounded 2^32 / interval_recip, restoring, one bit a cycle
    assign num       = 33'h1_0000_0000 + {3'd0, cfg.interval_recip[30:1]};
    assign rem_sh    = {rem_reg, num[dcnt_reg]};
    assign rem_ge    = (rem_sh >= {1'b0, cfg.interval_recip});
    assign quot_next = {quot_reg[31:0], rem_ge};
    assign frac_sum  = {1'b0, unit_reg} + {17'd0, frac_reg};

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_item   = out_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wtint_pkg::S_IDLE:   if (q_avail) state_next = wtint_pkg::S_DIV;
            wtint_pkg::S_DIV:    if (dcnt_reg == '0) state_next = wtint_pkg::S_UNIT;
            wtint_pkg::S_UNIT:   if (mul_done) state_next = wtint_pkg::S_VX;
            wtint_pkg::S_VX:     if (mul_done) state_next = wtint_pkg::S_VY;
            wtint_pkg::S_VY:     if (mul_done) state_next = wtint_pkg::S_ANGLE;
            wtint_pkg::S_ANGLE:  if (h1_ok_reg) state_next = wtint_pkg::S_VH;
            wtint_pkg::S_VH:     if (mul_done) state_next = wtint_pkg::S_STEP;
            wtint_pkg::S_STEP:   state_next = wtint_pkg::S_PX;
            wtint_pkg::S_PX:     if (mul_done) state_next = wtint_pkg::S_PY;
            wtint_pkg::S_PY:     if (mul_done) state_next = wtint_pkg::S_PH;
            wtint_pkg::S_PH:     if (mul_done) state_next = wtint_pkg::S_EMIT;
            wtint_pkg::S_EMIT: begin
                if (out_free) begin
                    state_next = (k_reg == K_LAST) ? wtint_pkg::S_FINISH : wtint_pkg::S_STEP;
                end
            end
            wtint_pkg::S_FINISH: state_next = wtint_pkg::S_IDLE;
            default:             state_next = wtint_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        q_pop  = (state_reg == wtint_pkg::S_IDLE) && q_avail;
        emit   = (state_reg == wtint_pkg::S_EMIT) && out_free;
        is_mul = 1'b1;
        mul_d  = '0;
        mul_f  = cfg.interval_recip;
        case (state_reg)
            wtint_pkg::S_UNIT: mul_d = $signed({3'd0, cfg.pt_period});
            wtint_pkg::S_VX:   mul_d = 34'(item_reg.dx);
            wtint_pkg::S_VY:   mul_d = 34'(item_reg.dy);
            wtint_pkg::S_VH:   mul_d = 34'(dh_reg);
            wtint_pkg::S_PX: begin
                mul_d = 34'(item_reg.dx);
                mul_f = frac_reg;
            end
            wtint_pkg::S_PY: begin
                mul_d = 34'(item_reg.dy);
                mul_f = frac_reg;
            end
            wtint_pkg::S_PH: begin
                mul_d = 34'(dh_reg);
                mul_f = frac_reg;
            end
            default: is_mul = 1'b0;
        endcase
        mul_start = is_mul && !mul_go_reg;
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg <= q_head;
            rem_reg  <= '0;
            quot_reg <= '0;
            dcnt_reg <= 6'd32;
        end
        if (state_reg == wtint_pkg::S_DIV) begin
            rem_reg  <= rem_ge ? 31'(rem_sh - {1'b0, cfg.interval_recip}) : rem_sh[30:0];
            quot_reg <= quot_next;
            dcnt_reg <= dcnt_reg - 6'd1;
            if (dcnt_reg == '0) begin
                if (cfg.interval_recip == '0 || quot_next[32:31] != 2'b00) begin
                    interval_reg <= wtint_pkg::TIME_MAX;
                end else begin
                    interval_reg <= quot_next[30:0];
                end
            end
        end
        if (cordic_done) begin
            h1_reg <= cordic_angle;
        end
        if (mul_done) begin
            case (state_reg)
                wtint_pkg::S_UNIT: unit_reg <= prod[46:0];
                wtint_pkg::S_VX:   vx_reg   <= vclamp(prod, cfg.max_speed);
                wtint_pkg::S_VY:   vy_reg   <= vclamp(prod, cfg.max_speed);
                wtint_pkg::S_VH:   vh_reg   <= vclamp(prod, cfg.max_speed);
                wtint_pkg::S_PX:   px_reg   <= pclamp(item_reg.x0, prod);
                wtint_pkg::S_PY:   py_reg   <= pclamp(item_reg.y0, prod);
                wtint_pkg::S_PH:   ph_reg   <= hclamp(h0_reg, prod);
                default: ;
            endcase
        end
        if (state_reg == wtint_pkg::S_UNIT) begin
            t_reg    <= 39'(item_reg.seg) * 39'(interval_reg);
            frac_reg <= '0;
        end
        if (state_reg == wtint_pkg::S_ANGLE) begin
            dh_reg <= 20'(h1_reg) - 20'(h0_reg);
        end
        if (state_reg == wtint_pkg::S_STEP) begin
            frac_reg <= (frac_sum > 48'h4000_0000) ? 31'h4000_0000 : frac_sum[30:0];
            t_reg    <= t_reg + {8'd0, cfg.pt_period};
        end
        if (emit) begin
            out_reg.time_from_start <= (t_reg > {8'd0, wtint_pkg::TIME_MAX})
                                       ? wtint_pkg::TIME_MAX : t_reg[30:0];
            out_reg.pos_x   <= px_reg;
            out_reg.pos_y   <= py_reg;
            out_reg.heading <= ph_reg;
            out_reg.vel_x   <= vx_reg;
            out_reg.vel_y   <= vy_reg;
            out_reg.vel_yaw <= vh_reg;
            out_reg.last    <= (k_reg == K_LAST);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= wtint_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            mul_go_reg    <= 1'b0;
            h1_ok_reg     <= 1'b0;
            h0_reg        <= '0;
            k_reg         <= '0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (mul_start) begin
                mul_go_reg <= 1'b1;
            end else if (mul_done) begin
                mul_go_reg <= 1'b0;
            end
            if (q_pop) begin
                h1_ok_reg <= 1'b0;
                k_reg     <= '0;
                if (q_head.new_path) begin
                    h0_reg <= '0;
                end
            end else if (cordic_done) begin
                h1_ok_reg <= 1'b1;
            end
            if (state_reg == wtint_pkg::S_STEP) begin
                k_reg <= k_reg + 1'b1;
            end
            if (state_reg == wtint_pkg::S_FINISH) begin
                h0_reg <= h1_reg;
            end
        end
    end

    `WTI_ASSERT_IMP(a_no_overwrite, aclk, aresetn, out_valid_reg && !m_tready, !emit, "result overwritten while held")
    `WTI_ASSERT_IMP(a_pop_idle, aclk, aresetn, q_pop, state_reg == wtint_pkg::S_IDLE, "segment taken while busy")
    `WTI_ASSERT_IMP(a_point_range, aclk, aresetn, emit, k_reg != '0 && k_reg <= K_LAST, "point index out of range")
    `WTI_ASSERT_NXT(a_mul_single, aclk, aresetn, mul_start, !mul_start, "multiply restarted while busy")
endmodule

// File: src/waypoint_trajectory_interpolator_top.sv
// Top level of the waypoint trajectory interpolator: ports, configuration
// registers, payload packing. Depends on wtint_pkg, wtint_front, wtint_queue, wtint_engine.
//
// Waypoints (Q16.16) enter as stream transactions; tuser marks the first
// waypoint of a new path, which starts from the origin with zero heading.
// Each of the first tracked_segments segments of a path yields
// POINTS_PER_SEGMENT interpolated points with timestamp, position, heading and
// clamped velocities; tlast flags the final point of a segment. Waypoints
// beyond the tracked segments are consumed without result. The front end
// keeps the previous point and segment count and queues up to two segments,
// so input is accepted while the engine works. The engine handles one segment
// at a time: it takes the segment from the queue, runs a bit-serial reciprocal
// divide (CORDIC heading runs alongside it), then uses the shared two-pass
// multiplier four times for the segment and three times per point, plus a
// step and an emit state per point and a state each for heading and wrap-up.
// The result sits in an output register so the next point is computed while
// one waits. Configuration writes are always accepted (cfg_ready high) and
// should be made only while the block is idle.
module waypoint_trajectory_interpolator_top #(
    parameter int POINTS_PER_SEGMENT = wtint_pkg::DEF_POINTS_PER_SEGMENT,
    parameter int CORDIC_ITERATIONS  = wtint_pkg::DEF_CORDIC_ITERATIONS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // way_x[31:0], way_y[63:32]
    input  logic         s_tuser,   // path_start
    output logic         m_tvalid,
    input  logic         m_tready,
    // time_from_start[30:0], pos_x[62:31], pos_y[94:63], heading[113:95],
    // vel_x[145:114], vel_y[177:146], vel_yaw[209:178], zero fill above
    output logic [215:0] m_tdata,
    output logic         m_tlast,   // segment_last
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [30:0]  cfg_data
);
    wtint_pkg::cfg_t      cfg_reg;
    wtint_pkg::seg_item_t push_item, head_item;
    wtint_pkg::out_item_t out_item;
    logic                 q_full, q_push, q_pop, q_avail;

    assign cfg_ready = 1'b1;

    // configuration register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_speed        <= wtint_pkg::RST_MAX_SPEED;
            cfg_reg.interval_recip   <= wtint_pkg::RST_INTERVAL_RECIP;
            cfg_reg.pt_period        <= wtint_pkg::RST_PT_PERIOD;
            cfg_reg.tracked_segments <= wtint_pkg::RST_TRACKED;
        end else if (cfg_valid) begin
            case (cfg_index)
                wtint_pkg::REG_MAX_SPEED:      cfg_reg.max_speed      <= cfg_data;
                wtint_pkg::REG_INTERVAL_RECIP: cfg_reg.interval_recip <= cfg_data;
                wtint_pkg::REG_PT_PERIOD:      cfg_reg.pt_period      <= cfg_data;
                wtint_pkg::REG_TRACKED:        cfg_reg.tracked_segments <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    wtint_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .way_x            ($signed(s_tdata[31:0])),
        .way_y            ($signed(s_tdata[63:32])),
        .path_start       (s_tuser),
        .tracked_segments (cfg_reg.tracked_segments),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_item           (push_item)
    );

    wtint_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .avail     (q_avail),
        .head      (head_item)
    );

    wtint_engine #(
        .POINTS_PER_SEGMENT (POINTS_PER_SEGMENT),
        .CORDIC_ITERATIONS  (CORDIC_ITERATIONS)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_avail  (q_avail),
        .q_head   (head_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_item   (out_item)
    );

    // result transaction packing
    assign m_tdata = {6'd0, out_item.vel_yaw, out_item.vel_y, out_item.vel_x,
                      out_item.heading, out_item.pos_y, out_item.pos_x,
                      out_item.time_from_start};
    assign m_tlast = out_item.last;
endmodule

// File: bench/waypoint_trajectory_interpolator_top_tb.sv
// Self-checking bench for the waypoint trajectory interpolator: directed table, then random paths.
// Depends on wtint_pkg and waypoint_trajectory_interpolator_top; expected points come from a
// local predictor of the segment heading, velocity and interpolation arithmetic.
module waypoint_trajectory_interpolator_top_tb;

    localparam int PTS = wtint_pkg::DEF_POINTS_PER_SEGMENT;
    localparam int ITERS = wtint_pkg::DEF_CORDIC_ITERATIONS > wtint_pkg::CORDIC_MAX_ITERATIONS
                           ? wtint_pkg::CORDIC_MAX_ITERATIONS : wtint_pkg::DEF_CORDIC_ITERATIONS;
    localparam longint HEAD_MAX = 205888;
    localparam longint HALF_TURN = 205887;
    localparam longint T_MAX = 64'h7FFF_FFFF;
    localparam longint ANG_STEP [24] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;      // way_x[31:0], way_y[63:32]
    logic         s_tuser;      // path_start
    logic         m_tvalid;
    logic         m_tready;
    logic [215:0] m_tdata;      // time, pos_x, pos_y, heading, vel_x, vel_y, vel_yaw
    logic         m_tlast;      // segment_last
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [30:0]  cfg_data;

    waypoint_trajectory_interpolator_top u_top (.*);

    // clock: 10 units per period
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // predictor state: its own copy of registers and path tracking
    logic [30:0] m_speed, m_recip, m_step;
    logic [6:0]  m_tracked;
    longint      p_x, p_y, p_head;
    int          p_seg;

    wtint_pkg::out_item_t points_due [$];
    int          errors;
    int          tx_idle, rx_idle, rx_hold;

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        if (errors < 60)
            $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    function automatic longint sat(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // (d * f) >> 16 with truncation toward zero, 64-bit product as in hardware reach
    function automatic longint q16_scale(input longint d, input logic [63:0] f);
        logic [63:0] m;
        m = d < 0 ? -d : d;
        m = (m * f) >> 16;
        return d < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint shift_mag(input longint v, input int s);
        logic [63:0] m;
        m = v < 0 ? -v : v;
        m = m >> s;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    // vectoring CORDIC atan2 on a pre-normalised vector
    function automatic longint segment_heading(input longint dy, input longint dx);
        longint x, y, z, xs, ys;
        if (dy == 0)
            return dx >= 0 ? 0 : HALF_TURN;
        x = dx;
        y = dy;
        z = 0;
        if (x < 0) begin
            z = y >= 0 ? HALF_TURN : -HALF_TURN;
            x = -x;
            y = -y;
        end
        while ((x < 0 ? -x : x) < (64'sd1 << 40) && (y < 0 ? -y : y) < (64'sd1 << 40)) begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < ITERS; i++) begin
            xs = shift_mag(x, i);
            ys = shift_mag(y, i);
            if (y > 0) begin
                x += ys; y -= xs; z += ANG_STEP[i];
            end else begin
                x -= ys; y += xs; z -= ANG_STEP[i];
            end
        end
        return sat(z, -HEAD_MAX, HEAD_MAX);
    endfunction

    function automatic longint clamped_rate(input longint d);
        return sat(q16_scale(d, m_recip), -longint'(m_speed), longint'(m_speed));
    endfunction

    // queues the points that one accepted waypoint gives
    task automatic predict_waypoint(input logic [31:0] wx, input logic [31:0] wy,
                                    input logic start);
        longint x1, y1, dx, dy, h1, dh, vx, vy, vh, interval, t;
        logic [63:0] unit, frac;
        wtint_pkg::out_item_t pt;
        x1 = longint'(signed'(wx));
        y1 = longint'(signed'(wy));
        if (start) begin
            p_x = 0; p_y = 0; p_head = 0; p_seg = 0;
        end
        if (p_seg >= m_tracked)
            return;
        dx = x1 - p_x;
        dy = y1 - p_y;
        h1 = segment_heading(dy, dx);
        dh = h1 - p_head;
        vx = clamped_rate(dx);
        vy = clamped_rate(dy);
        vh = clamped_rate(dh);
        if (m_recip == 0)
            interval = T_MAX;
        else
            interval = sat(longint'((64'h1_0000_0000 + (m_recip >> 1)) / m_recip), 0, T_MAX);
        unit = (64'(m_step) * 64'(m_recip)) >> 16;
        for (int k = 1; k <= PTS; k++) begin
            frac = k * unit;
            if (frac > (64'd1 << 30))
                frac = 64'd1 << 30;
            t = sat(longint'(p_seg) * interval + k * longint'(m_step), 0, T_MAX);
            pt.time_from_start = t[30:0];
            pt.pos_x   = 32'(sat(p_x + q16_scale(dx, frac),
                                 -(64'sd1 << 31), (64'sd1 << 31) - 1));
            pt.pos_y   = 32'(sat(p_y + q16_scale(dy, frac),
                                 -(64'sd1 << 31), (64'sd1 << 31) - 1));
            pt.heading = 19'(sat(p_head + q16_scale(dh, frac), -HEAD_MAX, HEAD_MAX));
            pt.vel_x   = 32'(vx);
            pt.vel_y   = 32'(vy);
            pt.vel_yaw = 32'(vh);
            pt.last    = (k == PTS);
            points_due = {points_due, pt};
        end
        p_x = x1;
        p_y = y1;
        p_head = h1;
        p_seg++;
    endtask

    // result side: every accepted point against the oldest expectation
    always @(posedge aclk) begin
        wtint_pkg::out_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (points_due.size() == 0) begin
                report("unexpected point, time", m_tdata[30:0], 0);
            end else begin
                want = points_due.pop_front();
                if (m_tdata[30:0] !== want.time_from_start)
                    report("time_from_start", m_tdata[30:0], want.time_from_start);
                if (m_tdata[62:31] !== want.pos_x)
                    report("pos_x", signed'(m_tdata[62:31]), want.pos_x);
                if (m_tdata[94:63] !== want.pos_y)
                    report("pos_y", signed'(m_tdata[94:63]), want.pos_y);
                if (m_tdata[113:95] !== want.heading)
                    report("heading", signed'(m_tdata[113:95]), want.heading);
                if (m_tdata[145:114] !== want.vel_x)
                    report("vel_x", signed'(m_tdata[145:114]), want.vel_x);
                if (m_tdata[177:146] !== want.vel_y)
                    report("vel_y", signed'(m_tdata[177:146]), want.vel_y);
                if (m_tdata[209:178] !== want.vel_yaw)
                    report("vel_yaw", signed'(m_tdata[209:178]), want.vel_yaw);
                if (m_tdata[215:210] !== 6'd0)
                    report("fill bits", m_tdata[215:210], 0);
                if (m_tlast !== want.last)
                    report("segment_last", m_tlast, want.last);
            end
        end
    end

    // receiver back-pressure; a long hold-off counts down here
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            wtint_pkg::REG_MAX_SPEED:      m_speed = val;
            wtint_pkg::REG_INTERVAL_RECIP: m_recip = val;
            wtint_pkg::REG_PT_PERIOD:      m_step = val;
            default:                       m_tracked = val[6:0];
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // one waypoint transaction; sender gaps come before the offer
    task automatic send_waypoint(input logic [31:0] wx, input logic [31:0] wy,
                                 input logic start);
        while ($urandom_range(99) < tx_idle) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {wy, wx};
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        predict_waypoint(wx, wy, start);
    endtask

    task automatic drain_points();
        while (points_due.size() != 0)
            @(posedge aclk);
    endtask

    task automatic go_quiet();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        drain_points();
        // let the engine finish its last segment
        repeat (200) @(posedge aclk);
    endtask

    task automatic set_config(input logic [30:0] spd, input logic [30:0] rcp,
                              input logic [30:0] stp, input logic [6:0] trk);
        go_quiet();
        write_reg(wtint_pkg::REG_MAX_SPEED, spd);
        write_reg(wtint_pkg::REG_INTERVAL_RECIP, rcp);
        write_reg(wtint_pkg::REG_PT_PERIOD, stp);
        write_reg(wtint_pkg::REG_TRACKED, {24'd0, trk});
    endtask

    function automatic logic [31:0] pick_coord(input logic [31:0] last);
        case ($urandom_range(9))
            0, 1, 2, 3: return 32'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
            4:          return $urandom;
            5:          return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            6:          return 32'd0;
            7:          return last;
            default:    return last + 32'(int'($urandom_range(0, 1 << 16)) - (1 << 15));
        endcase
    endfunction

    // random paths: mostly well-formed paths from a start, a few stray starts
    task automatic random_paths(input int count);
        logic [31:0] lx, ly;
        int left;
        lx = 0;
        ly = 0;
        left = 0;
        for (int n = 0; n < count; n++) begin
            logic st;
            st = (left == 0) || ($urandom_range(19) == 0);
            if (st)
                left = $urandom_range(1, 8);
            lx = pick_coord(lx);
            ly = pick_coord(ly);
            send_waypoint(lx, ly, st);
            left--;
        end
    endtask

    // directed rows; has_ref rows carry a typed first point
    typedef struct {
        logic [31:0] wx;
        logic [31:0] wy;
        logic        start;
        logic        has_ref;
        logic [30:0] t_first;
        logic [31:0] px_first;
    } way_row_t;

    way_row_t plan [15] = '{
        '{32'd0,          32'd0,          1'b1, 1'b1, 31'd1311, 32'd0},   // origin to origin
        '{32'd0,          32'd0,          1'b0, 1'b1, 31'd7865, 32'd0},   // second segment
        '{32'h0001_0000,  32'd0,          1'b0, 1'b0, 31'd0,    32'd0},
        '{32'hFFFF_0000,  32'd0,          1'b0, 1'b0, 31'd0,    32'd0},   // dy zero, dx negative
        '{32'h0001_0000,  32'h0001_0000,  1'b0, 1'b0, 31'd0,    32'd0},
        '{32'd5,          32'd7,          1'b0, 1'b0, 31'd0,    32'd0},   // beyond tracked
        '{32'h7FFF_FFFF,  32'h8000_0000,  1'b1, 1'b0, 31'd0,    32'd0},   // field extremes
        '{32'h8000_0000,  32'h7FFF_FFFF,  1'b0, 1'b0, 31'd0,    32'd0},
        '{32'h7FFF_FFFF,  32'h7FFF_FFFF,  1'b0, 1'b0, 31'd0,    32'd0},
        '{32'h8000_0000,  32'h8000_0000,  1'b0, 1'b0, 31'd0,    32'd0},
        '{32'hFFFF_FFFF,  32'hAAAA_5555,  1'b0, 1'b0, 31'd0,    32'd0},   // last tracked segment
        '{32'h0000_0000,  32'hFFFF_0000,  1'b1, 1'b0, 31'd0,    32'd0},   // straight down
        '{32'hFFFE_0000,  32'h0000_8000,  1'b0, 1'b0, 31'd0,    32'd0},
        '{32'h5555_AAAA,  32'h0000_0001,  1'b1, 1'b0, 31'd0,    32'd0},
        '{32'h0003_0000,  32'hFFFC_0000,  1'b1, 1'b0, 31'd0,    32'd0}
    };

    initial begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = wtint_pkg::REG_MAX_SPEED;
        cfg_data  = '0;
        errors    = 0;
        rx_hold   = 0;
        tx_idle   = 16;
        rx_idle   = 76;
        m_speed   = wtint_pkg::RST_MAX_SPEED;
        m_recip   = wtint_pkg::RST_INTERVAL_RECIP;
        m_step    = wtint_pkg::RST_PT_PERIOD;
        m_tracked = wtint_pkg::RST_TRACKED;
        p_x = 0; p_y = 0; p_head = 0; p_seg = 0;
        aresetn   = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            int base;
            base = points_due.size();
            send_waypoint(plan[i].wx, plan[i].wy, plan[i].start);
            if (plan[i].has_ref && points_due.size() > base) begin
                points_due[base].time_from_start = plan[i].t_first;
                points_due[base].pos_x = plan[i].px_first;
            end
        end

        // first idle mode: sender 16 %, receiver 76 %
        set_config(31'h7FFF_FFFF, 31'd1, 31'h7FFF_FFFF, 7'd1);
        random_paths(30);
        set_config(31'd0, 31'd0, 31'd0, 7'd0);   // nothing emitted
        random_paths(6);
        set_config(31'd0, 31'd0, 31'd0, 7'd2);   // zero reciprocal and step
        random_paths(12);

        // second idle mode: the other way round
        tx_idle = 76;
        rx_idle = 16;
        set_config(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd0, 7'd127);
        random_paths(30);
        set_config(31'($urandom), 31'($urandom), 31'($urandom), 7'($urandom_range(1, 10)));
        random_paths(40);

        // no idling; long receiver hold-off while waypoints keep coming
        tx_idle = 0;
        rx_idle = 0;
        set_config(31'($urandom_range(1 << 20)), wtint_pkg::RST_INTERVAL_RECIP,
                   wtint_pkg::RST_PT_PERIOD, 7'd64);
        rx_hold = 600;
        random_paths(25);
        // sender holds until all points are out
        @(negedge aclk);
        s_tvalid <= 1'b0;
        drain_points();
        random_paths(25);
        set_config(wtint_pkg::RST_MAX_SPEED, wtint_pkg::RST_INTERVAL_RECIP,
                   wtint_pkg::RST_PT_PERIOD, 7'd5);
        random_paths(40);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        drain_points();
        repeat (300) @(posedge aclk);
        if (errors == 0 && points_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
